// ===== src/lcdst_pkg.sv =====
// lcdst_pkg: types, constants and phase codes for the lcd scanline timing controller
// no dependencies; imported by every module of the block

package lcdst_pkg;

  // widths
  localparam int unsigned CycW  = 20;
  localparam int unsigned IntW  = 11;
  localparam int unsigned LineW = 8;
  localparam int unsigned EvW   = 16;
  localparam int unsigned ElapW = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // timing constants
  localparam logic [IntW-1:0]  DRAW_CYCLES   = 11'd960;
  localparam logic [IntW-1:0]  HBLANK_CYCLES = 11'd272;
  localparam logic [IntW-1:0]  VLINE_CYCLES  = 11'd1232;
  localparam logic [LineW-1:0] LAST_VISIBLE  = 8'd159;
  localparam logic [LineW-1:0] LAST_LINE     = 8'd227;
  localparam logic [CycW-1:0]  COUNT_MAX     = 20'hFFFFF;

  // status flag bit positions
  localparam int unsigned FlHblank = 0;
  localparam int unsigned FlVblank = 1;
  localparam int unsigned FlMatch  = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATCH_LINE   = 2'd0,
    CFG_MATCH_IRQ_EN = 2'd1,
    CFG_HBL_IRQ_EN   = 2'd2,
    CFG_VBL_IRQ_EN   = 2'd3
  } cfg_idx_e;

  // display phase
  typedef enum logic [1:0] {
    PH_DRAW   = 2'd0,
    PH_HBLANK = 2'd1,
    PH_VBLANK = 2'd2
  } phase_e;

  typedef struct packed {
    logic [LineW-1:0] match_line;
    logic             match_irq_enable;
    logic             hblank_irq_enable;
    logic             vblank_irq_enable;
  } cfg_t;

  typedef struct packed {
    phase_e           phase;
    logic [CycW-1:0]  cycle_count;
    logic [LineW-1:0] line_counter;
    logic [IntW-1:0]  next_interval;
    logic [2:0]       flag_bits;
  } seq_state_t;

  typedef struct packed {
    logic [ElapW-1:0] elapsed_cycles;
    logic [EvW-1:0]   next_event_in;
  } in_item_t;

  typedef struct packed {
    logic             frame_done;
    logic             hblank_irq;
    logic             vblank_irq;
    logic             match_irq;
    logic             hblank_dma_start;
    logic             vblank_dma_start;
    logic             render_valid;
    logic [LineW-1:0] render_line;
    logic             latch_scroll;
    logic [EvW-1:0]   next_event_out;
    logic [2:0]       status_bits;
    logic [LineW-1:0] current_line;
  } out_item_t;

endpackage

// ===== src/lcdst_cfg.sv =====
// lcdst_cfg: configuration register bank (match line and interrupt enables)
// depends on lcdst_pkg

module lcdst_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lcdst_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [lcdst_pkg::CfgDataW-1:0]      cfg_data_i,
  output lcdst_pkg::cfg_t                     cfg_o
);
  import lcdst_pkg::*;

  cfg_t cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MATCH_LINE:   cfg_q.match_line        <= cfg_data_i[LineW-1:0];
        CFG_MATCH_IRQ_EN: cfg_q.match_irq_enable  <= cfg_data_i[0];
        CFG_HBL_IRQ_EN:   cfg_q.hblank_irq_enable <= cfg_data_i[0];
        CFG_VBL_IRQ_EN:   cfg_q.vblank_irq_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/lcdst_step.sv =====
// lcdst_step: one sequencer step, combinational: count update, phase transition, result
// depends on lcdst_pkg

module lcdst_step (
  input  lcdst_pkg::cfg_t       cfg_i,
  input  lcdst_pkg::seq_state_t state_i,
  input  lcdst_pkg::in_item_t   item_i,
  output lcdst_pkg::seq_state_t state_o,
  output lcdst_pkg::out_item_t  result_o
);
  import lcdst_pkg::*;

  logic [CycW:0]    sum;
  logic [CycW-1:0]  cnt_sat;
  logic [LineW-1:0] line_inc;
  logic             line_hit;
  seq_state_t       st;
  out_item_t        res;

  // saturating add and incremented line
  always_comb begin
    sum      = {1'b0, state_i.cycle_count} + {(CycW + 1 - ElapW)'(0), item_i.elapsed_cycles};
    cnt_sat  = sum[CycW] ? COUNT_MAX : sum[CycW-1:0];
    line_inc = state_i.line_counter + LineW'(1);
    line_hit = (line_inc == cfg_i.match_line);
  end

  // phase transition
  always_comb begin
    st             = state_i;
    st.cycle_count = cnt_sat;
    res            = '0;
    case (state_i.phase)
      PH_DRAW: begin
        if (cnt_sat >= CycW'(DRAW_CYCLES)) begin
          st.cycle_count         = cnt_sat - CycW'(DRAW_CYCLES);
          st.phase               = PH_HBLANK;
          st.next_interval       = HBLANK_CYCLES;
          st.flag_bits[FlHblank] = 1'b1;
          res.hblank_irq         = cfg_i.hblank_irq_enable;
          res.hblank_dma_start   = 1'b1;
        end
      end
      PH_HBLANK: begin
        if (cnt_sat >= CycW'(HBLANK_CYCLES)) begin
          st.cycle_count         = cnt_sat - CycW'(HBLANK_CYCLES);
          st.flag_bits[FlHblank] = 1'b0;
          if (state_i.line_counter <= LAST_VISIBLE) begin
            res.render_valid = 1'b1;
            res.render_line  = state_i.line_counter;
            st.phase         = PH_DRAW;
            st.next_interval = DRAW_CYCLES;
          end else begin
            res.vblank_dma_start   = 1'b1;
            res.vblank_irq         = cfg_i.vblank_irq_enable;
            res.frame_done         = 1'b1;
            st.phase               = PH_VBLANK;
            st.flag_bits[FlVblank] = 1'b1;
            st.next_interval       = VLINE_CYCLES;
          end
          st.line_counter       = line_inc;
          st.flag_bits[FlMatch] = line_hit;
          res.match_irq         = line_hit & cfg_i.match_irq_enable;
        end
      end
      PH_VBLANK: begin
        if (cnt_sat >= CycW'(VLINE_CYCLES)) begin
          st.cycle_count        = cnt_sat - CycW'(VLINE_CYCLES);
          st.flag_bits[FlMatch] = line_hit;
          res.match_irq         = line_hit & cfg_i.match_irq_enable;
          // frame wrap past the last line
          if (line_inc > LAST_LINE) begin
            res.latch_scroll       = 1'b1;
            st.flag_bits[FlHblank] = 1'b0;
            st.flag_bits[FlVblank] = 1'b0;
            st.phase               = PH_DRAW;
            st.next_interval       = DRAW_CYCLES;
            st.line_counter        = '0;
          end else begin
            st.line_counter  = line_inc;
            st.next_interval = VLINE_CYCLES;
          end
        end
      end
      default: ;
    endcase

    // reported fields after the step
    res.next_event_out = (item_i.next_event_in < EvW'(st.next_interval))
                         ? item_i.next_event_in : EvW'(st.next_interval);
    res.status_bits    = st.flag_bits;
    res.current_line   = st.line_counter;
  end

  assign state_o  = st;
  assign result_o = res;

endmodule

// ===== src/lcd_scanline_timing_controller_core.sv =====
// lcd_scanline_timing_controller_core: top level, input register, sequencer state, result register
// depends on lcdst_pkg, lcdst_cfg, lcdst_step
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------
//  in       | in_valid_i / in_stall_o      | in_data_i  (in_item_t)
//  out      | out_valid_o / out_stall_i    | out_data_o (out_item_t)
//  cfg      | cfg_we_i (no wait)           | cfg_index_i, cfg_data_i
//
// one request per cycle while the output does not stall; a request's result reaches the output
// through the input register, then the step logic into the result register
// the sequencer state updates when a request moves from the input to the result register
// a stalled output holds the result and stalls the input once the input register is full
// reset clears the state to draw phase, line 0, count 0, interval 960, all enables off

module lcd_scanline_timing_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lcdst_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lcdst_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lcdst_pkg::in_item_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lcdst_pkg::out_item_t           out_data_o
);
  import lcdst_pkg::*;

  cfg_t       cfg;
  seq_state_t state_q, state_d;
  in_item_t   item_q;
  logic       item_vld_q;
  out_item_t  res_q, res_d;
  logic       res_vld_q;
  logic       res_free;
  logic       advance;

  lcdst_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lcdst_step u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // flow control
  assign res_free   = !res_vld_q || !out_stall_i;
  assign advance    = item_vld_q && res_free;
  assign in_stall_o = item_vld_q && !res_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= PH_DRAW;
      state_q.cycle_count   <= '0;
      state_q.line_counter  <= '0;
      state_q.next_interval <= DRAW_CYCLES;
      state_q.flag_bits     <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule
